// File: rtl/core/grd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grd_pkg: shared types and constants for the graph reachability engine
// Request codes, controller states, and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package grd_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int VERT_W       = 7;
    localparam int REQ_W        = 2;
    localparam int ROW_AW       = $clog2(MAX_VERTICES);

    typedef logic [MAX_VERTICES-1:0] t_row;
    typedef logic [ROW_AW-1:0]       t_addr;
    typedef logic [VERT_W-1:0]       t_vertex;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD_WR,
        S_QUERY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;      // drop every adjacency row
        logic add_start;  // latch edge, read source row
        logic add_write;  // write source row with new bit
        logic q_start;    // seed visited/pending from start vertex
        logic q_step;     // expand one pending vertex
        logic out_load;   // publish the query result
    } t_cmd;

    typedef struct packed {
        logic q_empty;    // nothing pending, nothing in flight
        logic out_free;   // output register can take a word
    } t_stat;

endpackage : grd_pkg
`default_nettype wire

// File: rtl/core/grd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grd_ctrl: request sequencer
// Decodes accepted requests and steps the datapath through edge updates
// and the query expansion loop.
// ----------------------------------------------------------------------------
module grd_ctrl
    import grd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [REQ_W-1:0] i_req_type,
    input  wire t_stat            i_stat,
    output t_cmd                  o_cmd,
    output logic                  o_in_stall
);

    t_state r_state;
    t_state n_state;
    t_req   req;
    logic   accept;

    assign req    = t_req'(i_req_type);
    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (req)
                        REQ_ADD:   n_state = S_ADD_WR;
                        REQ_QUERY: n_state = S_QUERY;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_WR: n_state = S_IDLE;
            S_QUERY: begin
                if (i_stat.q_empty) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.clear     = accept && (req == REQ_CLEAR);
                o_cmd.add_start = accept && (req == REQ_ADD);
                o_cmd.q_start   = accept && (req == REQ_QUERY);
            end
            S_ADD_WR: o_cmd.add_write = 1'b1;
            S_QUERY:  o_cmd.q_step    = 1'b1;
            S_DONE:   o_cmd.out_load  = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule : grd_ctrl
`default_nettype wire

// File: rtl/core/grd_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grd_path: adjacency memory, visited/pending sets, result register
// One adjacency row is read per cycle; the returned row is merged into the
// visited and pending sets while the next pending vertex is picked.
// ----------------------------------------------------------------------------
module grd_path
    import grd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    input  wire t_vertex i_src_vertex,
    input  wire t_vertex i_dst_vertex,
    input  wire logic    i_out_stall,
    output t_stat        o_stat,
    output logic         o_out_valid,
    output logic         o_reachable
);

    function automatic t_addr vtx_addr(t_vertex v);
        t_addr a;
        a = '0;
        for (int i = 0; i < ROW_AW; i++) begin
            if (i < VERT_W) a[i] = v[i];
        end
        return a;
    endfunction

    function automatic logic vtx_ok(t_vertex v);
        return int'(v) < MAX_VERTICES;
    endfunction

    function automatic t_addr lowest_bit(t_row r);
        t_addr idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (r[i]) idx = t_addr'(i);
        end
        return idx;
    endfunction

    t_row  mem [MAX_VERTICES];
    t_row  r_row_valid;
    t_row  r_rd_data;
    logic  r_rd_ok;
    logic  r_inflight;
    t_row  r_visited;
    t_row  r_pending;
    t_addr r_src_addr;
    t_addr r_dst_addr;
    logic  r_edge_ok;
    logic  r_q_ok;
    logic  r_out_valid;
    logic  r_reachable;

    t_row  rd_row;
    t_row  fresh;
    t_row  cand;
    t_addr sel;
    logic  rd_en;
    t_addr rd_addr;
    logic  wr_en;
    t_row  wr_data;

    // rows never written since the last clear read as zero
    assign rd_row  = r_rd_ok ? r_rd_data : '0;
    assign fresh   = r_inflight ? (rd_row & ~r_visited) : '0;
    assign cand    = r_pending | fresh;
    assign sel     = lowest_bit(cand);

    assign rd_en   = i_cmd.add_start || (i_cmd.q_step && (cand != '0));
    assign rd_addr = i_cmd.add_start ? vtx_addr(i_src_vertex) : sel;
    assign wr_en   = i_cmd.add_write && r_edge_ok;
    assign wr_data = rd_row | (t_row'(1) << r_dst_addr);

    assign o_stat.q_empty  = (cand == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_reachable     = r_reachable;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_src_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
            r_inflight  <= 1'b0;
            r_visited   <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_row_valid <= '0;
            end else if (wr_en) begin
                r_row_valid[r_src_addr] <= 1'b1;
            end

            if (rd_en) begin
                r_rd_ok <= r_row_valid[rd_addr];
            end

            if (i_cmd.q_start) begin
                r_inflight <= 1'b0;
                if (vtx_ok(i_src_vertex) && vtx_ok(i_dst_vertex)) begin
                    r_visited <= t_row'(1) << vtx_addr(i_src_vertex);
                    r_pending <= t_row'(1) << vtx_addr(i_src_vertex);
                end
            end else if (i_cmd.q_step) begin
                r_visited  <= r_visited | fresh;
                r_pending  <= cand & ~(t_row'(1) << sel);
                r_inflight <= (cand != '0);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_start) begin
            r_src_addr <= vtx_addr(i_src_vertex);
            r_dst_addr <= vtx_addr(i_dst_vertex);
            r_edge_ok  <= vtx_ok(i_src_vertex) && vtx_ok(i_dst_vertex);
        end else if (i_cmd.q_start) begin
            r_dst_addr <= vtx_addr(i_dst_vertex);
            r_q_ok     <= vtx_ok(i_src_vertex) && vtx_ok(i_dst_vertex);
        end
        if (i_cmd.out_load) begin
            r_reachable <= r_q_ok && r_visited[r_dst_addr];
        end
    end

endmodule : grd_path
`default_nettype wire

// File: rtl/core/graph_reachability_dfs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// graph_reachability_dfs: directed-graph reachability engine
// Keeps a 128 x 128 adjacency bit matrix; answers whether one vertex can
// reach another by expanding visited vertices one row per cycle.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | word
//  ---------+---------------------------+------------------------------------
//  request  | i_in_valid / o_in_stall   | i_req_type, i_src_vertex, i_dst_vertex
//  result   | o_out_valid / i_out_stall | o_reachable (queries only)
//
//  Clear acts on acceptance; add edge does a row read, then a row write.
//  A query seeds the sets from the start vertex, expands until nothing is
//  pending, then publishes: one adjacency memory read per expanded vertex.
//  Reset clears the row valid bits at once; no clearing pass.
//  A new request is taken while a result waits in the output register; a
//  query only stalls at its end if the previous result is still unread.
// ----------------------------------------------------------------------------
module graph_reachability_dfs
    import grd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [REQ_W-1:0] i_req_type,
    input  wire logic [VERT_W-1:0] i_src_vertex,
    input  wire logic [VERT_W-1:0] i_dst_vertex,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_reachable
);

    t_cmd  cmd;
    t_stat stat;

    grd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    grd_path u_path (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_src_vertex (i_src_vertex),
        .i_dst_vertex (i_dst_vertex),
        .i_out_stall  (i_out_stall),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_reachable  (o_reachable)
    );

    // a result word appears only when the controller publishes one
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("result word without a publish");

    // expansion never runs while requests are being taken
    a_step_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.q_step |-> o_in_stall)
        else $error("query step while input open");

    // a publish never overwrites an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result overwritten");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule : graph_reachability_dfs
`default_nettype wire

// File: bench/graph_reachability_dfs_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the graph reachability engine
// Drives clear, add-edge, query and no-op words. An in-bench adjacency matrix
// predicts each query answer, and the answer is checked against the result
// channel in order. Runs under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
    import grd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic [REQ_W-1:0]    i_req_type   = '0;
    logic [VERT_W-1:0]   i_src_vertex = '0;
    logic [VERT_W-1:0]   i_dst_vertex = '0;
    logic                i_out_stall  = 1'b0;
    wire logic           o_in_stall;
    wire logic           o_out_valid;
    wire logic           o_reachable;

    graph_reachability_dfs dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_src_vertex (i_src_vertex),
        .i_dst_vertex (i_dst_vertex),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reachable  (o_reachable)
    );

    // predicted graph and pending query answers
    t_row        adj_rows [MAX_VERTICES];
    bit          reach_q [$];
    bit          expected_reach;
    int          errors       = 0;
    int          quiet_cycles = 0;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    t_vertex     window_base  = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Walk pending vertices lowest first until none is left.
    function automatic bit trace_reach(t_vertex from_v, t_vertex to_v);
        t_row seen;
        t_row frontier;
        t_row fresh;
        int   v;
        seen         = '0;
        seen[from_v] = 1'b1;
        frontier     = seen;
        while (frontier != '0) begin
            v = 0;
            while (!frontier[v]) v++;
            frontier[v] = 1'b0;
            fresh       = adj_rows[v] & ~seen;
            seen       |= fresh;
            frontier   |= fresh;
        end
        return seen[to_v];
    endfunction

    // Mostly vertices near the current window so queries find real paths.
    function automatic t_vertex pick_vertex();
        if ($urandom_range(0, 99) < 85) begin
            return t_vertex'(window_base + $urandom_range(0, 11));
        end
        return t_vertex'($urandom_range(0, MAX_VERTICES - 1));
    endfunction

    task automatic send_word(t_req req, t_vertex src, t_vertex dst);
        int i;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_src_vertex <= src;
        i_dst_vertex <= dst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (req)
            REQ_CLEAR: begin
                for (i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
            end
            REQ_ADD:   adj_rows[src][dst] = 1'b1;
            REQ_QUERY: reach_q.push_back(trace_reach(src, dst));
            default:   ;
        endcase
    endtask

    task automatic test_directed();
        send_word(REQ_QUERY, 7'd0,   7'd0);
        send_word(REQ_QUERY, 7'd0,   7'd127);
        send_word(REQ_ADD,   7'd0,   7'd127);
        send_word(REQ_ADD,   7'd0,   7'd127);
        send_word(REQ_QUERY, 7'd0,   7'd127);
        send_word(REQ_QUERY, 7'd127, 7'd0);
        send_word(REQ_ADD,   7'd127, 7'd0);
        send_word(REQ_QUERY, 7'd127, 7'd0);
        // unused request code must leave the graph alone
        send_word(REQ_NONE,  7'd5,   7'd6);
        send_word(REQ_QUERY, 7'd5,   7'd6);
        send_word(REQ_ADD,   7'd1,   7'd2);
        send_word(REQ_ADD,   7'd2,   7'd3);
        send_word(REQ_ADD,   7'd3,   7'd64);
        send_word(REQ_QUERY, 7'd1,   7'd64);
        send_word(REQ_QUERY, 7'd64,  7'd1);
        send_word(REQ_ADD,   7'd64,  7'd1);
        send_word(REQ_QUERY, 7'd2,   7'd1);
        send_word(REQ_CLEAR, 7'd0,   7'd0);
        send_word(REQ_QUERY, 7'd0,   7'd127);
        send_word(REQ_QUERY, 7'd1,   7'd64);
        send_word(REQ_QUERY, 7'd127, 7'd127);
        send_word(REQ_ADD,   7'd85,  7'd42);
        send_word(REQ_QUERY, 7'd85,  7'd42);
        send_word(REQ_QUERY, 7'd42,  7'd85);
    endtask

    // One path through every vertex: the longest query the block can see.
    task automatic test_long_chain();
        t_vertex order [MAX_VERTICES];
        t_vertex tmp;
        int      i;
        int      j;
        for (i = 0; i < MAX_VERTICES; i++) order[i] = t_vertex'(i);
        for (i = MAX_VERTICES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        send_word(REQ_CLEAR, '0, '0);
        for (i = MAX_VERTICES - 2; i >= 0; i--) send_word(REQ_ADD, order[i], order[i + 1]);
        send_word(REQ_QUERY, order[0], order[MAX_VERTICES - 1]);
        send_word(REQ_QUERY, order[MAX_VERTICES - 1], order[0]);
        repeat (4) begin
            send_word(REQ_QUERY, order[$urandom_range(0, MAX_VERTICES - 1)],
                      order[$urandom_range(0, MAX_VERTICES - 1)]);
        end
    endtask

    task automatic test_random_graph(int count);
        int unsigned pick;
        t_vertex     a;
        t_vertex     b;
        repeat (count) begin
            if ($urandom_range(0, 49) == 0) window_base = t_vertex'($urandom);
            pick = $urandom_range(0, 99);
            a    = pick_vertex();
            b    = pick_vertex();
            if (pick < 2)       send_word(REQ_CLEAR, a, b);
            else if (pick < 5)  send_word(REQ_NONE, a, b);
            else if (pick < 60) send_word(REQ_ADD, a, b);
            else                send_word(REQ_QUERY, a, b);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reach_q.size() == 0) begin
                $display("%0t: result word with none expected: actual reachable=%0b",
                         $time, o_reachable);
                errors++;
            end else begin
                expected_reach = reach_q.pop_front();
                if (o_reachable !== expected_reach) begin
                    $display("%0t: reachable mismatch: expected %0b actual %0b",
                             $time, expected_reach, o_reachable);
                    errors++;
                end
            end
        end
    end

    // nothing moving on either channel for too long means a hang
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct  = 0;
        stall_pct = 0;
        test_directed();
        test_random_graph(220);

        idle_pct = 49;
        test_random_graph(220);

        idle_pct  = 0;
        stall_pct = 49;
        test_long_chain();
        test_random_graph(220);

        idle_pct  = 23;
        stall_pct = 23;
        test_random_graph(220);

        i_in_valid <= 1'b0;
        while (reach_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && reach_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/grd_pkg.sv
rtl/core/grd_ctrl.sv
rtl/core/grd_path.sv
rtl/core/graph_reachability_dfs.sv
bench/graph_reachability_dfs_tb.sv
